/* design/mmac_pkg.sv */
// Shared types, codes and saturation helpers for the matrix multiply-accumulate.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mmac_pkg;

  localparam int AB_W  = 16;   // Q8.8 element width of A and B
  localparam int C_W   = 40;   // Q24.16 element width of C
  localparam int P_W   = 32;   // exact product width
  localparam int DIM_W = 5;    // dimension register width
  localparam int IDX_W = 4;    // row / column field width
  localparam int CFG_W = 2;    // configuration index width

  typedef enum logic [2:0] {
    MODE_WR_A = 3'd0,
    MODE_WR_B = 3'd1,
    MODE_WR_C = 3'd2,
    MODE_COMP = 3'd3,
    MODE_RD_C = 3'd4
  } mode_e;

  localparam logic [CFG_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  function automatic logic signed [AB_W-1:0] sat16(input logic signed [C_W-1:0] v);
    logic signed [AB_W-1:0] r;
    if (v > C_W'(signed'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -C_W'(signed'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[AB_W-1:0];
    end
    return r;
  endfunction

  // Saturate a one-bit-grown sum back to the C width.
  function automatic logic signed [C_W-1:0] sat40(input logic signed [C_W:0] v);
    logic signed [C_W-1:0] r;
    if (v[C_W] != v[C_W-1]) begin
      r = v[C_W] ? {1'b1, {(C_W-1){1'b0}}} : {1'b0, {(C_W-1){1'b1}}};
    end else begin
      r = v[C_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/mmac_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mmac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* design/mmac_cell.sv */
// One MAC cell of the chain: holds column K of A and row K of B, adds one product.
// Depends on mmac_pkg and mmac_ram.
`timescale 1ns / 1ps
`default_nettype none
module mmac_cell import mmac_pkg::*; #(
  parameter int AW  = 4,
  parameter int CW  = 5,
  parameter int K   = 0
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    wr_a_i,
  input  wire logic                    wr_b_i,
  input  wire logic [AW-1:0]           wr_addr_i,
  input  wire logic signed [AB_W-1:0]  wr_data_i,
  input  wire logic [CW-1:0]           nk_i,
  input  wire logic                    in_valid_i,
  input  wire logic [AW-1:0]           in_i_i,
  input  wire logic [AW-1:0]           in_j_i,
  input  wire logic signed [C_W-1:0]   in_acc_i,
  output logic                         out_valid_o,
  output logic [AW-1:0]                out_i_o,
  output logic [AW-1:0]                out_j_o,
  output logic signed [C_W-1:0]        out_acc_o
);

  localparam int BANK_DEPTH = 1 << AW;

  logic [AB_W-1:0]        a_rdata, b_rdata;
  logic                   s1_valid_q, s2_valid_q, s2_use_q;
  logic [AW-1:0]          s1_i_q, s1_j_q, s2_i_q, s2_j_q;
  logic signed [C_W-1:0]  s1_acc_q, s2_acc_q;
  logic signed [P_W-1:0]  s2_prod_q, s2_prod_d;
  logic signed [C_W:0]    sum;

  mmac_ram #(.WIDTH(AB_W), .DEPTH(BANK_DEPTH)) u_a_bank (
    .clk_i, .we_i(wr_a_i), .waddr_i(wr_addr_i), .wdata_i(wr_data_i),
    .raddr_i(in_i_i), .rdata_o(a_rdata)
  );

  mmac_ram #(.WIDTH(AB_W), .DEPTH(BANK_DEPTH)) u_b_bank (
    .clk_i, .we_i(wr_b_i), .waddr_i(wr_addr_i), .wdata_i(wr_data_i),
    .raddr_i(in_j_i), .rdata_o(b_rdata)
  );

  assign s2_prod_d = $signed(a_rdata) * $signed(b_rdata);
  assign sum = {s2_acc_q[C_W-1], s2_acc_q}
             + (s2_use_q ? {{(C_W+1-P_W){s2_prod_q[P_W-1]}}, s2_prod_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_i_q    <= in_i_i;
    s1_j_q    <= in_j_i;
    s1_acc_q  <= in_acc_i;
    s2_i_q    <= s1_i_q;
    s2_j_q    <= s1_j_q;
    s2_acc_q  <= s1_acc_q;
    s2_prod_q <= s2_prod_d;
    s2_use_q  <= (K < 32'(nk_i));   // cells past inner_len pass through
    out_i_o   <= s2_i_q;
    out_j_o   <= s2_j_q;
    out_acc_o <= sat40(sum);
  end

endmodule
`default_nettype wire

/* design/matrix_multiply_accumulate.sv */
// Matrix multiply-accumulate, C += A * B, over a chain of MAX_DIM MAC cells.
// A load is written at its transfer; a read waits for the C store read and raises
// its result once the result register is free; a compute issues nr*nc C elements
// (one C element enters the chain per cycle, each passes all cells), waits for the
// chain to drain, then raises its result; it goes straight to its result if nr or nc is zero.
// One item at a time; the input is ready only while the sequencer is idle.
// Reset clears the control registers and sets the dimension registers to 16; stores are not cleared.
// Depends on mmac_pkg, mmac_cell, mmac_ram.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_accumulate import mmac_pkg::*; #(
  parameter int MAX_DIM = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_W-1:0]       cfg_addr_i,
  input  wire logic [DIM_W-1:0]       cfg_wdata_i,
  // input items
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [2:0]             mode_i,
  input  wire logic [IDX_W-1:0]       row_index_i,
  input  wire logic [IDX_W-1:0]       col_index_i,
  input  wire logic signed [C_W-1:0]  value_i,
  // results
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [C_W-1:0]       result_value_o,
  output logic [IDX_W-1:0]            result_row_o,
  output logic [IDX_W-1:0]            result_col_o,
  output logic                        compute_done_o
);

  localparam int AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;   // index bits
  localparam int CW  = $clog2(MAX_DIM + 1);                   // dimension count bits
  localparam int IFW = $clog2(3 * MAX_DIM + 3);               // in-flight count bits
  localparam int C_DEPTH = 1 << (2 * AW);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_WAIT, ST_RD_RESP, ST_ISSUE, ST_DRAIN, ST_CP_RESP
  } state_e;

  state_e                state_q;
  logic [DIM_W-1:0]      rows_a_q, inner_len_q, cols_b_q;
  logic [CW-1:0]         nr, nk, nc;
  logic [AW-1:0]         i_q, j_q;
  logic [IFW-1:0]        inflight_q;
  logic                  issue_valid_q;
  logic [AW-1:0]         issue_i_q, issue_j_q;
  logic [2*AW-1:0]       rd_addr_q;
  logic [IDX_W-1:0]      rd_row_q, rd_col_q;
  logic                  rd_ok_q;

  logic                  in_fire, in_range, out_slot;
  mode_e                 mode;
  logic [AW-1:0]         row_w, col_w;
  logic signed [AB_W-1:0] ab_data;

  // C store
  logic                  c_we;
  logic [2*AW-1:0]       c_waddr, c_raddr;
  logic [C_W-1:0]        c_wdata, c_rdata;

  // cell chain
  logic                  ch_valid [MAX_DIM+1];
  logic [AW-1:0]         ch_i     [MAX_DIM+1];
  logic [AW-1:0]         ch_j     [MAX_DIM+1];
  logic signed [C_W-1:0] ch_acc   [MAX_DIM+1];

  // dimensions above MAX_DIM act as MAX_DIM
  function automatic logic [CW-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    return (32'(d) > MAX_DIM) ? CW'(MAX_DIM) : CW'(d);
  endfunction

  assign nr = clamp_dim(rows_a_q);
  assign nk = clamp_dim(inner_len_q);
  assign nc = clamp_dim(cols_b_q);

  assign mode     = mode_e'(mode_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;
  assign in_range = (32'(row_index_i) < MAX_DIM) && (32'(col_index_i) < MAX_DIM);
  assign row_w    = AW'(row_index_i);
  assign col_w    = AW'(col_index_i);
  assign ab_data  = sat16(value_i);
  assign out_slot = !out_valid_o || out_ready_i;

  // C store ports: chain write-back during compute, load otherwise
  always_comb begin
    c_we    = ch_valid[MAX_DIM];
    c_waddr = {ch_i[MAX_DIM], ch_j[MAX_DIM]};
    c_wdata = ch_acc[MAX_DIM];
    if (in_fire && (mode == MODE_WR_C) && in_range) begin
      c_we    = 1'b1;
      c_waddr = {row_w, col_w};
      c_wdata = value_i;
    end
  end

  assign c_raddr = (state_q == ST_ISSUE) ? {i_q, j_q} : rd_addr_q;

  mmac_ram #(.WIDTH(C_W), .DEPTH(C_DEPTH)) u_c_store (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  // chain head: the C element read in the previous cycle enters cell 0
  assign ch_valid[0] = issue_valid_q;
  assign ch_i[0]     = issue_i_q;
  assign ch_j[0]     = issue_j_q;
  assign ch_acc[0]   = $signed(c_rdata);

  // cell K owns A column K and B row K
  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    logic wr_a, wr_b;
    assign wr_a = in_fire && (mode == MODE_WR_A) && in_range && (32'(col_index_i) == k);
    assign wr_b = in_fire && (mode == MODE_WR_B) && in_range && (32'(row_index_i) == k);

    mmac_cell #(.AW(AW), .CW(CW), .K(k)) u_cell (
      .clk_i, .rst_ni,
      .wr_a_i(wr_a), .wr_b_i(wr_b),
      .wr_addr_i(wr_a ? row_w : col_w),
      .wr_data_i(ab_data),
      .nk_i(nk),
      .in_valid_i(ch_valid[k]), .in_i_i(ch_i[k]), .in_j_i(ch_j[k]),
      .in_acc_i(ch_acc[k]),
      .out_valid_o(ch_valid[k+1]), .out_i_o(ch_i[k+1]), .out_j_o(ch_j[k+1]),
      .out_acc_o(ch_acc[k+1])
    );
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_len_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_wdata_i;
        CFG_INNER_LEN: inner_len_q <= cfg_wdata_i;
        CFG_COLS_B:    cols_b_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // read request capture (payload only)
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_addr_q <= {row_w, col_w};
      rd_row_q  <= row_index_i;
      rd_col_q  <= col_index_i;
      rd_ok_q   <= in_range;
    end
    issue_i_q <= i_q;
    issue_j_q <= j_q;
  end

  // sequencer, result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      i_q            <= '0;
      j_q            <= '0;
      inflight_q     <= '0;
      issue_valid_q  <= 1'b0;
      out_valid_o    <= 1'b0;
      result_value_o <= '0;
      result_row_o   <= '0;
      result_col_o   <= '0;
      compute_done_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      issue_valid_q <= (state_q == ST_ISSUE);
      inflight_q <= inflight_q + IFW'(state_q == ST_ISSUE) - IFW'(ch_valid[MAX_DIM]);

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (mode)
              MODE_RD_C: state_q <= ST_RD_WAIT;
              MODE_COMP: begin
                i_q <= '0;
                j_q <= '0;
                state_q <= ((nr == '0) || (nc == '0)) ? ST_CP_RESP : ST_ISSUE;
              end
              default: ;
            endcase
          end
        end
        ST_RD_WAIT: state_q <= ST_RD_RESP;
        ST_RD_RESP: begin
          if (out_slot) begin
            out_valid_o    <= 1'b1;
            result_value_o <= rd_ok_q ? $signed(c_rdata) : '0;
            result_row_o   <= rd_row_q;
            result_col_o   <= rd_col_q;
            compute_done_o <= 1'b0;
            state_q        <= ST_IDLE;
          end
        end
        ST_ISSUE: begin
          if (CW'(j_q) == nc - CW'(1)) begin
            j_q <= '0;
            if (CW'(i_q) == nr - CW'(1)) begin
              state_q <= ST_DRAIN;
            end else begin
              i_q <= i_q + AW'(1);
            end
          end else begin
            j_q <= j_q + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (inflight_q == '0) begin
            state_q <= ST_CP_RESP;
          end
        end
        ST_CP_RESP: begin
          if (out_slot) begin
            out_valid_o    <= 1'b1;
            result_value_o <= '0;
            result_row_o   <= '0;
            result_col_o   <= '0;
            compute_done_o <= 1'b1;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/mmac_checker.sv */
// Port-level checks for the matrix multiply-accumulate, bound to the top level.
// Depends on mmac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmac_checker import mmac_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic [2:0]            mode_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic signed [C_W-1:0] result_value_o,
  input wire logic [IDX_W-1:0]      result_row_o,
  input wire logic [IDX_W-1:0]      result_col_o,
  input wire logic                  compute_done_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o)
      && $stable(compute_done_o))
    else $error("result changed while stalled");

  // compute acknowledgement carries zero payload
  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compute_done_o |->
      (result_value_o == '0) && (result_row_o == '0) && (result_col_o == '0))
    else $error("compute acknowledgement with nonzero payload");

  // a read or compute transfer blocks the input in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && ((mode_i == MODE_COMP) || (mode_i == MODE_RD_C))
      |=> !in_ready_o)
    else $error("input ready while a read or compute is pending");

endmodule

bind matrix_multiply_accumulate mmac_checker u_mmac_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .out_valid_o, .out_ready_i,
  .result_value_o, .result_row_o, .result_col_o, .compute_done_o
);
`default_nettype wire

/* sim/matrix_multiply_accumulate_test.sv */
// Self-checking testbench for matrix_multiply_accumulate (C += A * B, fixed point).
// A queue-fed driver and a monitor check results against an in-bench predictor.
// Depends on mmac_pkg and the matrix_multiply_accumulate RTL.
`timescale 1ns / 1ps
module matrix_multiply_accumulate_test;
  import mmac_pkg::*;

  localparam int          DIM        = 16;
  localparam int          DEPTH      = DIM * DIM;
  localparam int          ITEM_GOAL  = 1300;
  localparam int          LIMIT      = 600000;   // cycles; the worst correct run is far below
  localparam int          SETTLE     = 12;       // idle cycles before a register write
  localparam int          TAIL       = 400;      // covers the longest compute latency
  localparam logic [2:0]  MODE_SPARE = 3'd5;     // first unused mode code (5..7 are ignored)

  localparam logic signed [C_W-1:0] C_TOP = {1'b0, {(C_W-1){1'b1}}};
  localparam logic signed [C_W-1:0] C_BOT = {1'b1, {(C_W-1){1'b0}}};

  typedef enum logic [1:0] {ENT_ITEM, ENT_CFG, ENT_DRAIN} entry_kind_e;

  typedef struct {
    entry_kind_e             kind;
    logic [2:0]              mode;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [C_W-1:0]   value;
    logic [CFG_W-1:0]        reg_idx;
    logic [DIM_W-1:0]        reg_val;
  } entry_t;

  typedef struct {
    logic signed [C_W-1:0] value;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    logic                  done;
  } result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  logic                  cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]      cfg_addr_i  = '0;
  logic [DIM_W-1:0]      cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [2:0]            mode_i      = '0;
  logic [IDX_W-1:0]      row_index_i = '0;
  logic [IDX_W-1:0]      col_index_i = '0;
  logic signed [C_W-1:0] value_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [C_W-1:0] result_value_o;
  logic [IDX_W-1:0]      result_row_o;
  logic [IDX_W-1:0]      result_col_o;
  logic                  compute_done_o;

  matrix_multiply_accumulate #(.MAX_DIM(DIM)) DUT (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .mode_i, .row_index_i, .col_index_i, .value_i,
    .out_valid_o, .out_ready_i, .result_value_o, .result_row_o, .result_col_o,
    .compute_done_o
  );

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the stores and the dimension registers
  // ---------------------------------------------------------------------------
  logic signed [AB_W-1:0] mat_a [DEPTH];
  logic signed [AB_W-1:0] mat_b [DEPTH];
  logic signed [C_W-1:0]  mat_c [DEPTH];
  logic [DIM_W-1:0]       dim_rows = DIM_RESET;
  logic [DIM_W-1:0]       dim_inner = DIM_RESET;
  logic [DIM_W-1:0]       dim_cols = DIM_RESET;

  result_t pending_results[$];    // results still owed by the DUT
  int      errors = 0;
  int      computes_seen = 0;
  int      reads_seen = 0;

  function automatic logic signed [AB_W-1:0] clip_q88(logic signed [C_W-1:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    if (v < -40'sd32768) return 16'sh8000;
    return v[AB_W-1:0];
  endfunction

  function automatic int eff_dim(logic [DIM_W-1:0] d);
    return (d > DIM) ? DIM : int'(d);
  endfunction

  // Whole C += A * B pass; the running sum saturates after every product.
  function automatic void mac_pass();
    int nr, nk, nc;
    logic signed [C_W-1:0]   acc;
    logic signed [P_W-1:0]   prod;
    logic signed [C_W:0]     sum;
    nr = eff_dim(dim_rows);
    nk = eff_dim(dim_inner);
    nc = eff_dim(dim_cols);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = mat_c[i*DIM+j];
        for (int k = 0; k < nk; k++) begin
          prod = mat_a[i*DIM+k] * mat_b[k*DIM+j];
          sum  = acc + prod;
          if (sum > $signed({1'b0, C_TOP})) acc = C_TOP;
          else if (sum < $signed({1'b1, C_BOT})) acc = C_BOT;
          else acc = sum[C_W-1:0];
        end
        mat_c[i*DIM+j] = acc;
      end
    end
  endfunction

  function automatic void predict_item(logic [2:0] md, logic [IDX_W-1:0] r,
                                       logic [IDX_W-1:0] c, logic signed [C_W-1:0] v);
    int      addr;
    result_t res;
    addr = int'(r) * DIM + int'(c);
    case (md)
      MODE_WR_A: mat_a[addr] = clip_q88(v);
      MODE_WR_B: mat_b[addr] = clip_q88(v);
      MODE_WR_C: mat_c[addr] = v;
      MODE_COMP: begin
        mac_pass();
        res = '{value: '0, row: '0, col: '0, done: 1'b1};
        pending_results.push_back(res);
      end
      MODE_RD_C: begin
        res = '{value: mat_c[addr], row: r, col: c, done: 1'b0};
        pending_results.push_back(res);
      end
      default: ;  // unused modes are dropped by the block
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation (fills the queue at time zero)
  // ---------------------------------------------------------------------------
  entry_t     to_send[$];
  bit         gen_a [DEPTH];     // entries written so far, as seen by the generator
  bit         gen_b [DEPTH];
  bit         gen_c [DEPTH];
  int         gen_dims [3];
  int         gen_items = 0;     // items in modes 0..4
  bit         all_filled = 1'b0;

  function automatic void add_item(logic [2:0] md, int r, int c, logic signed [C_W-1:0] v);
    entry_t e;
    e = '{kind: ENT_ITEM, mode: md, row: IDX_W'(r), col: IDX_W'(c), value: v,
          reg_idx: '0, reg_val: '0};
    to_send.push_back(e);
    if (md <= MODE_RD_C) gen_items++;
    if (md == MODE_WR_A) gen_a[r*DIM+c] = 1'b1;
    if (md == MODE_WR_B) gen_b[r*DIM+c] = 1'b1;
    if (md == MODE_WR_C) gen_c[r*DIM+c] = 1'b1;
  endfunction

  function automatic void add_cfg(logic [CFG_W-1:0] idx, int d);
    entry_t e;
    e = '{kind: ENT_CFG, mode: '0, row: '0, col: '0, value: '0,
          reg_idx: idx, reg_val: DIM_W'(d)};
    to_send.push_back(e);
    gen_dims[idx] = d;
  endfunction

  function automatic void set_dims(int r, int k, int c);
    add_cfg(CFG_ROWS_A, r);
    add_cfg(CFG_INNER_LEN, k);
    add_cfg(CFG_COLS_B, c);
  endfunction

  function automatic logic signed [C_W-1:0] rand40();
    return {8'($urandom_range(0, 255)), $urandom()};
  endfunction

  // Mostly in-range Q8.8, with oversized values to hit the clipping.
  function automatic logic signed [C_W-1:0] ab_value();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $signed(16'($urandom()));
    if (p < 92) return rand40();
    if (p < 96) return C_TOP;
    return C_BOT;
  endfunction

  function automatic logic signed [C_W-1:0] c_value();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return $signed(28'($urandom()));
    if (p < 80) return rand40();
    if (p < 90) return C_TOP - C_W'($urandom_range(0, 1 << 20));
    return C_BOT + C_W'($urandom_range(0, 1 << 20));
  endfunction

  function automatic int pick_dim();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return 0;
    if (p < 70) return $urandom_range(1, 4);
    if (!all_filled || p < 85) return $urandom_range(5, 8);
    if (p < 91) return $urandom_range(9, 16);
    if (p < 95) return $urandom_range(17, 30);
    return 31;
  endfunction

  // A compute reads only the region that the current dimensions cover.
  function automatic void fill_region();
    int nr, nk, nc;
    nr = (gen_dims[0] > DIM) ? DIM : gen_dims[0];
    nk = (gen_dims[1] > DIM) ? DIM : gen_dims[1];
    nc = (gen_dims[2] > DIM) ? DIM : gen_dims[2];
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!gen_a[i*DIM+k]) add_item(MODE_WR_A, i, k, ab_value());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!gen_b[k*DIM+j]) add_item(MODE_WR_B, k, j, ab_value());
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++)
        if (!gen_c[i*DIM+j]) add_item(MODE_WR_C, i, j, c_value());
  endfunction

  // Read back a C entry that has been written (never an untouched one).
  function automatic void read_some(int n);
    int a;
    for (int t = 0; t < n; t++) begin
      a = $urandom_range(0, DEPTH - 1);
      for (int s = 0; s < DEPTH && !gen_c[a]; s++) a = (a + 1) % DEPTH;
      if (gen_c[a]) add_item(MODE_RD_C, a / DIM, a % DIM, '0);
    end
  endfunction

  // Random writes and ignored modes, sprinkled between the useful items.
  function automatic void noise(int n);
    int p;
    for (int t = 0; t < n; t++) begin
      p = $urandom_range(0, 9);
      if (p < 3) add_item(MODE_WR_A, $urandom_range(0, 15), $urandom_range(0, 15), ab_value());
      else if (p < 6) add_item(MODE_WR_B, $urandom_range(0, 15), $urandom_range(0, 15),
                               ab_value());
      else if (p < 9) add_item(MODE_WR_C, $urandom_range(0, 15), $urandom_range(0, 15),
                               c_value());
      else add_item(MODE_SPARE + 3'($urandom_range(0, 2)), $urandom_range(0, 15),
                    $urandom_range(0, 15), rand40());
    end
  endfunction

  function automatic void directed_part();
    entry_t e;
    set_dims(1, 1, 1);
    // positive clipping on A, the largest Q8.8 value on B, then accumulation past the top
    add_item(MODE_WR_A, 0, 0, C_TOP);
    add_item(MODE_WR_B, 0, 0, 40'sd32767);
    add_item(MODE_WR_C, 0, 0, C_TOP - 5);
    add_item(MODE_COMP, 0, 0, '0);
    add_item(MODE_RD_C, 0, 0, '0);
    // negative clipping, accumulation past the bottom
    add_item(MODE_WR_A, 0, 0, C_BOT);
    add_item(MODE_WR_C, 0, 0, C_BOT + 3);
    add_item(MODE_COMP, 0, 0, '0);
    add_item(MODE_RD_C, 0, 0, '0);
    // most negative times most negative is a large positive product
    add_item(MODE_WR_B, 0, 0, -40'sd32768);
    add_item(MODE_COMP, 0, 0, '0);
    add_item(MODE_RD_C, 0, 0, '0);
    // far corner of the index space, and the unused modes
    add_item(MODE_WR_C, 15, 15, C_BOT);
    add_item(MODE_RD_C, 15, 15, '0);
    add_item(MODE_WR_A, 15, 15, -40'sd1);
    add_item(MODE_WR_B, 15, 15, 40'sd1);
    add_item(MODE_SPARE, 3, 4, rand40());
    add_item(MODE_SPARE + 3'd1, 15, 15, C_TOP);
    add_item(MODE_SPARE + 3'd2, 0, 0, C_BOT);
    // a zero inner dimension leaves C as it was
    set_dims(1, 0, 1);
    add_item(MODE_COMP, 0, 0, '0);
    add_item(MODE_RD_C, 0, 0, '0);
    // zero rows and zero columns
    set_dims(0, 1, 0);
    add_item(MODE_COMP, 0, 0, '0);
    e = '{kind: ENT_DRAIN, mode: '0, row: '0, col: '0, value: '0, reg_idx: '0, reg_val: '0};
    to_send.push_back(e);
  endfunction

  function automatic void random_part();
    int phase = 0;
    while (gen_items < ITEM_GOAL) begin
      if (phase == 6) begin
        // one pass at full size writes every entry; afterwards any size is legal
        set_dims(DIM, DIM, DIM);
        fill_region();
        all_filled = 1'b1;
      end else if (phase == 9) begin
        set_dims(31, 31, 31);
      end else begin
        set_dims(pick_dim(), pick_dim(), pick_dim());
        noise($urandom_range(0, 8));
        fill_region();
      end
      for (int n = $urandom_range(1, 3); n > 0; n--) begin
        noise($urandom_range(0, 4));
        read_some($urandom_range(0, 2));
        add_item(MODE_COMP, $urandom_range(0, 15), $urandom_range(0, 15), rand40());
        read_some($urandom_range(1, 6));
      end
      phase++;
    end
  endfunction

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      gen_a[i] = 1'b0;
      gen_b[i] = 1'b0;
      gen_c[i] = 1'b0;
    end
    gen_dims = '{DIM, DIM, DIM};
    directed_part();
    random_part();
  end

  // ---------------------------------------------------------------------------
  // Driver: one entry at a time; register writes wait until the block is idle
  // ---------------------------------------------------------------------------
  int items_sent = 0;
  int idle_run = 0;
  int send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t           e;
    logic             vld;
    logic             we;
    logic [2:0]       md;
    logic [IDX_W-1:0] r, c;
    logic signed [C_W-1:0] v;
    logic [CFG_W-1:0] ra;
    logic [DIM_W-1:0] rd;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
    end else begin
      vld = in_valid_i;
      we  = 1'b0;
      md = mode_i; r = row_index_i; c = col_index_i; v = value_i;
      ra = cfg_addr_i; rd = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        predict_item(mode_i, row_index_i, col_index_i, value_i);
        items_sent++;
        vld = 1'b0;
      end
      // the block has nothing in flight once no result is owed for a while
      if (pending_results.size() == 0 && !in_valid_i) idle_run++;
      else idle_run = 0;
      if (!vld) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (to_send.size() != 0) begin
          e = to_send[0];
          if (e.kind == ENT_ITEM) begin
            void'(to_send.pop_front());
            vld = 1'b1;
            md = e.mode; r = e.row; c = e.col; v = e.value;
            // every fourth stretch of 120 items runs back to back
            send_gap = ((items_sent / 120) % 4 == 3) ? 0 : $urandom_range(0, 18);
          end else if (idle_run >= SETTLE && in_ready_o) begin
            void'(to_send.pop_front());
            if (e.kind == ENT_CFG) begin
              we = 1'b1;
              ra = e.reg_idx;
              rd = e.reg_val;
              case (e.reg_idx)
                CFG_ROWS_A:    dim_rows  = e.reg_val;
                CFG_INNER_LEN: dim_inner = e.reg_val;
                CFG_COLS_B:    dim_cols  = e.reg_val;
                default: ;
              endcase
            end
          end
        end
      end
      in_valid_i  <= vld;
      mode_i      <= md;
      row_index_i <= r;
      col_index_i <= c;
      value_i     <= v;
      cfg_we_i    <= we;
      cfg_addr_i  <= ra;
      cfg_wdata_i <= rd;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and result-side stalls
  // ---------------------------------------------------------------------------
  int  results_taken = 0;
  int  hold_cnt = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int      h;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      h = hold_cnt;
      if (out_valid_o && out_ready_i) begin
        results_taken++;
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: value %0d row %0d col %0d done %0b",
                 result_value_o, result_row_o, result_col_o, compute_done_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (compute_done_o) computes_seen++;
          else reads_seen++;
          if (result_value_o !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, result_value_o);
            errors++;
          end
          if (result_row_o !== want.row) begin
            $error("result_row: expected %0d, got %0d", want.row, result_row_o);
            errors++;
          end
          if (result_col_o !== want.col) begin
            $error("result_col: expected %0d, got %0d", want.col, result_col_o);
            errors++;
          end
          if (compute_done_o !== want.done) begin
            $error("compute_done: expected %0b, got %0b", want.done, compute_done_o);
            errors++;
          end
        end
        // one long hold-off backs up the block while the driver keeps offering
        if (results_taken == 300 && !long_hold_done) begin
          h = 500;
          long_hold_done = 1'b1;
        end else begin
          h = ((results_taken / 100) % 4 == 2) ? 0 : $urandom_range(0, 18);
        end
      end else if (h > 0) begin
        h--;
      end
      hold_cnt = h;
      out_ready_i <= (h == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog and end of run
  // ---------------------------------------------------------------------------
  int cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    while (to_send.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    $display("covered %0d transfers in, %0d computes and %0d reads of C checked",
             items_sent, computes_seen, reads_seen);
    $display("dimensions swept from 0 to 31, clipping and saturation at both ends");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
